### rtl/tmsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmsp_pkg;

    // Tag bytes that open a section
    localparam logic [7:0] TAG_MODEL   = 8'd7;
    localparam logic [7:0] TAG_VERTEX  = 8'd42;
    localparam logic [7:0] TAG_INDEX   = 8'd69;
    localparam logic [7:0] TAG_TEXTURE = 8'd96;

    // Token kinds
    localparam logic [3:0] TOK_COUNT    = 4'd0;
    localparam logic [3:0] TOK_NAME_CH  = 4'd1;
    localparam logic [3:0] TOK_NAME_END = 4'd2;
    localparam logic [3:0] TOK_TEX_CH   = 4'd3;
    localparam logic [3:0] TOK_TEX_END  = 4'd4;
    localparam logic [3:0] TOK_VCOUNT   = 4'd5;
    localparam logic [3:0] TOK_VWORD    = 4'd6;
    localparam logic [3:0] TOK_ICOUNT   = 4'd7;
    localparam logic [3:0] TOK_IWORD    = 4'd8;
    localparam logic [3:0] TOK_CORRUPT  = 4'd9;

    // Input beat: one file byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    // Output beat: one token
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  model_index;
        logic [31:0] token_value;
        logic        float_native;
        logic        int_native;
    } t_out_beat;

endpackage

`default_nettype wire

### rtl/tmsp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tmsp_core #(
    parameter int unsigned MAX_MODELS = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  tmsp_pkg::t_in_beat   i_beat,
    output logic                 o_tok_valid,
    output tmsp_pkg::t_out_beat  o_tok
);
    import tmsp_pkg::*;

    localparam logic [31:0] FLOAT_LO_BITS = 32'h40D3_3333;
    localparam logic [31:0] FLOAT_HI_BITS = 32'h40D6_6666;
    localparam logic [31:0] INT_MAGIC     = 32'd666;
    localparam logic [31:0] MODEL_LIMIT   = 32'(MAX_MODELS);
    localparam logic [3:0]  HDR_FLOAT_END = 4'd4;
    localparam logic [3:0]  HDR_INT_END   = 4'd8;
    localparam logic [3:0]  HDR_END       = 4'd12;

    typedef enum logic [3:0] {
        PH_HEADER, PH_TAG, PH_NAME, PH_TEX, PH_VLEN,
        PH_VDATA, PH_ILEN, PH_IDATA, PH_DEAD
    } t_phase;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    t_phase      r_phase, n_phase;
    logic [1:0]  r_bpos, n_bpos;
    logic [3:0]  r_hcount, n_hcount;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_remain, n_remain;
    logic [7:0]  r_model, n_model;
    logic        r_have_model, n_have_model;
    logic [31:0] r_declared, n_declared;
    logic        r_float_nat, n_float_nat;
    logic        r_int_nat, n_int_nat;
    logic        r_corrupt, n_corrupt;

    logic        tok_valid;
    logic [3:0]  tok_kind;
    logic [31:0] tok_value;

    // Per-byte parse step
    always_comb begin
        logic [7:0]  b;
        logic [31:0] shifted;
        logic [31:0] word;
        logic [8:0]  next_model;
        logic        native;

        b          = i_beat.data_byte;
        shifted    = {r_shift[23:0], b};
        next_model = r_have_model ? ({1'b0, r_model} + 9'd1) : 9'd0;
        native     = (r_phase == PH_VDATA) ? r_float_nat : r_int_nat;
        word       = native ? swap32(shifted) : shifted;

        n_phase      = r_phase;
        n_bpos       = r_bpos;
        n_hcount     = r_hcount;
        n_shift      = r_shift;
        n_remain     = r_remain;
        n_model      = r_model;
        n_have_model = r_have_model;
        n_declared   = r_declared;
        n_float_nat  = r_float_nat;
        n_int_nat    = r_int_nat;
        n_corrupt    = r_corrupt;
        tok_valid    = 1'b0;
        tok_kind     = TOK_COUNT;
        tok_value    = 32'd0;

        case (r_phase)
            PH_HEADER: begin
                n_shift  = shifted;
                n_hcount = r_hcount + 4'd1;
                if (n_hcount == HDR_FLOAT_END) begin
                    n_float_nat = (swap32(shifted) > FLOAT_LO_BITS) &&
                                  (swap32(shifted) < FLOAT_HI_BITS);
                end else if (n_hcount == HDR_INT_END) begin
                    n_int_nat = (swap32(shifted) == INT_MAGIC);
                end else if (n_hcount == HDR_END) begin
                    n_declared = r_int_nat ? swap32(shifted) : shifted;
                    n_shift    = 32'd0;
                    n_hcount   = 4'd0;
                    n_phase    = PH_TAG;
                    tok_valid  = 1'b1;
                    tok_kind   = TOK_COUNT;
                    tok_value  = n_declared;
                end
            end
            PH_TAG: begin
                if (b == TAG_MODEL) begin
                    // Model index overflow counts as a bad tag
                    if (({23'd0, next_model} >= r_declared) ||
                        ({23'd0, next_model} >= MODEL_LIMIT) || next_model[8]) begin
                        n_corrupt = 1'b1;
                        n_phase   = PH_DEAD;
                        tok_valid = 1'b1;
                        tok_kind  = TOK_CORRUPT;
                        tok_value = {24'd0, b};
                    end else begin
                        n_model      = next_model[7:0];
                        n_have_model = 1'b1;
                        n_phase      = PH_NAME;
                    end
                end else if (!(b inside {TAG_TEXTURE, TAG_VERTEX, TAG_INDEX}) ||
                             !r_have_model) begin
                    n_corrupt = 1'b1;
                    n_phase   = PH_DEAD;
                    tok_valid = 1'b1;
                    tok_kind  = TOK_CORRUPT;
                    tok_value = {24'd0, b};
                end else begin
                    n_bpos  = 2'd0;
                    n_shift = 32'd0;
                    if (b == TAG_TEXTURE) begin
                        n_phase = PH_TEX;
                    end else if (b == TAG_VERTEX) begin
                        n_phase = PH_VLEN;
                    end else begin
                        n_phase = PH_ILEN;
                    end
                end
            end
            PH_NAME, PH_TEX: begin
                tok_valid = 1'b1;
                if (b == 8'd0) begin
                    n_phase  = PH_TAG;
                    tok_kind = (r_phase == PH_NAME) ? TOK_NAME_END : TOK_TEX_END;
                end else begin
                    tok_kind  = (r_phase == PH_NAME) ? TOK_NAME_CH : TOK_TEX_CH;
                    tok_value = {24'd0, b};
                end
            end
            PH_VLEN, PH_ILEN, PH_VDATA, PH_IDATA: begin
                if (r_bpos != 2'd3) begin
                    n_shift = shifted;
                    n_bpos  = r_bpos + 2'd1;
                end else begin
                    n_bpos    = 2'd0;
                    n_shift   = 32'd0;
                    tok_valid = 1'b1;
                    tok_value = word;
                    if (r_phase == PH_VLEN || r_phase == PH_ILEN) begin
                        // Length word
                        tok_kind = (r_phase == PH_VLEN) ? TOK_VCOUNT : TOK_ICOUNT;
                        n_remain = word;
                        if (word == 32'd0) begin
                            n_phase = PH_TAG;
                        end else begin
                            n_phase = (r_phase == PH_VLEN) ? PH_VDATA : PH_IDATA;
                        end
                    end else begin
                        // Payload word, length rounded up to whole words
                        tok_kind = (r_phase == PH_VDATA) ? TOK_VWORD : TOK_IWORD;
                        if (r_remain <= 32'd4) begin
                            n_remain = 32'd0;
                            n_phase  = PH_TAG;
                        end else begin
                            n_remain = r_remain - 32'd4;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Token fields use the state before this byte
    assign o_tok_valid        = tok_valid;
    assign o_tok.token_kind   = tok_kind;
    assign o_tok.model_index  = r_model;
    assign o_tok.token_value  = tok_value;
    assign o_tok.float_native = r_float_nat;
    assign o_tok.int_native   = r_int_nat;

    // Parser state; last byte of a file restarts at the header
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.last_byte)) begin
            r_phase      <= PH_HEADER;
            r_bpos       <= 2'd0;
            r_hcount     <= 4'd0;
            r_shift      <= 32'd0;
            r_remain     <= 32'd0;
            r_model      <= 8'd0;
            r_have_model <= 1'b0;
            r_declared   <= 32'd0;
            r_float_nat  <= 1'b0;
            r_int_nat    <= 1'b0;
            r_corrupt    <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bpos       <= n_bpos;
            r_hcount     <= n_hcount;
            r_shift      <= n_shift;
            r_remain     <= n_remain;
            r_model      <= n_model;
            r_have_model <= n_have_model;
            r_declared   <= n_declared;
            r_float_nat  <= n_float_nat;
            r_int_nat    <= n_int_nat;
            r_corrupt    <= n_corrupt;
        end
    end

endmodule

`default_nettype wire

### rtl/tagged_model_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake              | Beat
// in      | input     | i_in_valid / o_in_stall  | t_in_beat  (data_byte, last_byte)
// out     | output    | o_out_valid / i_out_stall| t_out_beat (token fields)
//
// One byte per cycle while the output is not stalled; a token reaches the output
// register when its byte moves from the input register into the parser.
// Bytes that produce no token pass through without using an output slot.
// Synchronous active-low reset returns the parser to the header; no clearing pass.
// Output stall backs up into o_in_stall only when both registers are full.

module tagged_model_stream_parser_top #(
    parameter int unsigned MAX_MODELS = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  tmsp_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output tmsp_pkg::t_out_beat  o_out_beat
);
    import tmsp_pkg::*;

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic      advance;
    logic      tok_valid;
    t_out_beat tok;

    // Byte moves into the parser when the result register has room
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    tmsp_core #(
        .MAX_MODELS (MAX_MODELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_beat      (r_in_beat),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= tok_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && tok_valid) begin
            r_out_beat <= tok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire
